>>> src/hsfp_pkg.sv
package hsfp_pkg;

    // Widths of the byte path and of the configuration port.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LIMIT_W     = 9;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned PHASE_W     = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_TWO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0]  HDR_ONE_RST  = 8'h55;
    localparam logic [BYTE_W-1:0]  HDR_TWO_RST  = 8'hAA;
    localparam logic [LIMIT_W-1:0] ID_LIMIT_RST = 9'd256;

    // Parser phases.
    localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ID    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;

    // Live configuration handed to the parser.
    typedef struct packed {
        logic [BYTE_W-1:0]  hdr_one;
        logic [BYTE_W-1:0]  hdr_two;
        logic [LIMIT_W-1:0] id_limit;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        logic              frame_good;
        logic              frame_bad;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_length;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
    } t_result;

endpackage

>>> src/hsfp_in_if.sv
interface hsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/hsfp_out_if.sv
interface hsfp_out_if;
    logic       valid;
    logic       ready;
    logic       frame_good;
    logic       frame_bad;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;

    modport source (output valid, output frame_good, output frame_bad, output frame_id,
                    output frame_length, output payload_valid, output payload_byte,
                    output payload_index, input ready);
    modport sink   (input valid, input frame_good, input frame_bad, input frame_id,
                    input frame_length, input payload_valid, input payload_byte,
                    input payload_index, output ready);
endinterface

>>> src/header_sum_frame_parser_unit.sv
// Header-and-sum frame parser. Each input beat carries one received byte, and each
// accepted byte gives exactly one result beat, which is registered before it is offered.
// The parser hunts for two sync bytes, an id below the limit, a length byte, that many
// payload bytes streamed out with their index, and a check byte flagged good or bad
// against the 8-bit sum of all earlier frame bytes. One byte can be taken every cycle
// while the output keeps up: the phase update and 8-bit add sit between the input and a
// two-slot output register, whose spare slot keeps the input ready registered. Input is
// held off only while both slots are full. The user must write configuration only while the
// block is idle (the block does not enforce this); registers 0 and 1 are the sync bytes, 2 the 9-bit id limit.
module header_sum_frame_parser_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hsfp_in_if.sink                           in_ch,
    hsfp_out_if.source                        out_ch,
    input  logic                              i_cfg_we,
    input  logic [hsfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hsfp_pkg::*;

    t_cfg    r_cfg;
    t_result parse_result;
    t_result out_result;
    logic    push;
    logic    in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_one  <= HDR_ONE_RST;
            r_cfg.hdr_two  <= HDR_TWO_RST;
            r_cfg.id_limit <= ID_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HDR_ONE:  r_cfg.hdr_one  <= i_cfg_data[BYTE_W-1:0];
                CFG_HDR_TWO:  r_cfg.hdr_two  <= i_cfg_data[BYTE_W-1:0];
                CFG_ID_LIMIT: r_cfg.id_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_ch.ready = in_ready;
    assign push        = in_ch.valid && in_ready;

    hsfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (push),
        .i_byte   (in_ch.rx_byte),
        .i_cfg    (r_cfg),
        .o_result (parse_result)
    );

    hsfp_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parse_result),
        .o_ready  (in_ready),
        .o_valid  (out_ch.valid),
        .i_ready  (out_ch.ready),
        .o_result (out_result)
    );

    // Result beat onto the output channel.
    assign out_ch.frame_good    = out_result.frame_good;
    assign out_ch.frame_bad     = out_result.frame_bad;
    assign out_ch.frame_id      = out_result.frame_id;
    assign out_ch.frame_length  = out_result.frame_length;
    assign out_ch.payload_valid = out_result.payload_valid;
    assign out_ch.payload_byte  = out_result.payload_byte;
    assign out_ch.payload_index = out_result.payload_index;

endmodule

>>> src/hsfp_parse.sv
module hsfp_parse (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [hsfp_pkg::BYTE_W-1:0]        i_byte,
    input  hsfp_pkg::t_cfg                     i_cfg,
    output hsfp_pkg::t_result                  o_result
);
    import hsfp_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_sum, n_sum;
    logic [BYTE_W-1:0]  r_seen, n_seen;
    logic [BYTE_W-1:0]  r_id, n_id;
    logic [BYTE_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0]  sum_add;
    logic [BYTE_W-1:0]  seen_inc;

    assign sum_add  = r_sum + i_byte;
    assign seen_inc = r_seen + 8'd1;

    // Next state and the result of the byte on the input.
    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_seen   = r_seen;
        n_id     = r_id;
        n_len    = r_len;
        o_result = '0;
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == i_cfg.hdr_one) begin
                    n_sum   = i_byte;
                    n_seen  = '0;
                    n_id    = '0;
                    n_len   = '0;
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (i_byte == i_cfg.hdr_two) begin
                    n_sum   = sum_add;
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_ID: begin
                if ({1'b0, i_byte} < i_cfg.id_limit) begin
                    n_id    = i_byte;
                    n_sum   = sum_add;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_sum   = sum_add;
                n_phase = (i_byte == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = r_seen;
                n_seen = seen_inc;
                n_sum  = sum_add;
                if (seen_inc >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_result.frame_good = (r_sum == i_byte);
                o_result.frame_bad  = (r_sum != i_byte);
                n_phase = PH_HUNT1;
            end
            default: begin
                n_phase = PH_HUNT1;
            end
        endcase
        o_result.frame_id     = n_id;
        o_result.frame_length = n_len;
    end

    // Parser state advances once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_sum   <= '0;
            r_seen  <= '0;
            r_id    <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_seen  <= n_seen;
            r_id    <= n_id;
            r_len   <= n_len;
        end
    end

endmodule

>>> src/hsfp_skid.sv
module hsfp_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hsfp_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output hsfp_pkg::t_result o_result
);
    import hsfp_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    // The second slot catches a beat when the output stalls, so ready is registered.
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign pop      = r_main_valid && i_ready;

    // Occupancy of the two slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload of the two slots.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

endmodule

>>> src/hsfp_check.sv
module hsfp_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_frame_good,
    input logic i_frame_bad,
    input logic i_payload_valid
);

    // A beat is never both a good and a bad check byte.
    a_good_bad_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_frame_good && i_frame_bad))
        else $error("frame_good and frame_bad both set");

    // A payload beat never carries a check flag.
    a_payload_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_payload_valid) |-> !(i_frame_good || i_frame_bad))
        else $error("payload beat carries a check flag");

    // Input is held off only while a result beat is waiting.
    a_ready_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

endmodule

bind header_sum_frame_parser_unit hsfp_check u_hsfp_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (in_ch.ready),
    .i_out_valid     (out_ch.valid),
    .i_out_ready     (out_ch.ready),
    .i_frame_good    (out_ch.frame_good),
    .i_frame_bad     (out_ch.frame_bad),
    .i_payload_valid (out_ch.payload_valid)
);
